FILE: src/dmm_pkg.sv
// Shared constants for the differential-drive motor mixer.
package dmm_pkg;

  localparam int SPEED_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int WB_W      = 12;
  localparam int MS_W      = 15;
  localparam int MC_W      = 7;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  localparam int CMD_W     = 8;
  localparam int CMD_MAG_W = 7;
  localparam int CMD_FULL  = 127;

  localparam int LIM_SHIFT = 11;
  localparam int LIM_W     = MS_W + LIM_SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COMMAND = 2'd2;

  localparam logic [WB_W-1:0] WB_RESET = 12'd264;
  localparam logic [MS_W-1:0] MS_RESET = 15'd1024;
  localparam logic [MC_W-1:0] MC_RESET = 7'd50;

endpackage

FILE: src/dmm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module dmm_div_pipe #(
  parameter int LANES = 2,
  parameter int DW    = 26,
  parameter int QW    = 15,
  parameter int SW    = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem [LANES],
  input  logic [QW-1:0] in_low [LANES],
  input  logic [DW-1:0] in_div [LANES],
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo [LANES],
  output logic [SW-1:0] out_side
);

  logic [DW-1:0] rem_r   [QW][LANES];
  logic [DW-1:0] rem_nxt [QW][LANES];
  logic [QW-1:0] low_r   [QW][LANES];
  logic [QW-1:0] low_nxt [QW][LANES];
  logic [DW-1:0] div_r   [QW][LANES];
  logic [DW-1:0] div_nxt [QW][LANES];
  logic [SW-1:0] side_r   [QW];
  logic [SW-1:0] side_nxt [QW];
  logic [QW-1:0] vld_r;
  logic [QW-1:0] vld_nxt;

  always_comb begin
    logic [DW-1:0] pr;
    logic [QW-1:0] pl;
    logic [DW-1:0] pd;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        vld_nxt[k]  = in_valid;
        side_nxt[k] = in_side;
      end else begin
        vld_nxt[k]  = vld_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          pr = in_rem[l];
          pl = in_low[l];
          pd = in_div[l];
        end else begin
          pr = rem_r[k-1][l];
          pl = low_r[k-1][l];
          pd = div_r[k-1][l];
        end
        t    = {pr, pl[QW-1]};
        diff = t - {1'b0, pd};
        ge   = (t >= {1'b0, pd});
        rem_nxt[k][l] = ge ? diff[DW-1:0] : t[DW-1:0];
        low_nxt[k][l] = {pl[QW-2:0], ge};
        div_nxt[k][l] = pd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      div_r  <= div_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = low_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

FILE: src/diff_drive_motor_mixer.sv
// Top level of the differential-drive motor mixer pipeline.
// Turns a linear speed and a turn rate into left and right motor commands in
// the range -127..127. One transaction is accepted per clock while in_stall
// is low. Stages 1 to 4 feed two bit-per-stage dividers, wheel speed over
// full-scale speed and then the minimum-command rescale, with stages 5 and 6
// between them and an output register last. A stalled result at the output
// freezes the whole pipeline, so in_stall follows out_valid and out_stall.
// Configuration writes take effect at once and belong between transactions.
module diff_drive_motor_mixer #(
  parameter int SPEED_WIDTH = dmm_pkg::SPEED_WIDTH_DEF,
  parameter int FRAC_BITS   = dmm_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SPEED_WIDTH-1:0]  in_linear_speed,
  input  logic signed [SPEED_WIDTH-1:0]  in_turn_rate,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [dmm_pkg::CMD_W-1:0] out_left_command,
  output logic signed [dmm_pkg::CMD_W-1:0] out_right_command
);

  import dmm_pkg::*;

  localparam int SUM_W = SPEED_WIDTH + 13;
  localparam int CW    = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int QW    = CMD_MAG_W + FRAC_BITS;
  localparam int P1_W  = LIM_W + CMD_MAG_W;
  localparam int P2_W  = 2 * QW;
  localparam logic [QW-1:0] FULL = QW'(CMD_FULL) << FRAC_BITS;

  logic [WB_W-1:0] wheel_base_r;
  logic [MS_W-1:0] max_speed_r;
  logic [MC_W-1:0] min_command_r;

  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_base_r  <= WB_RESET;
      max_speed_r   <= MS_RESET;
      min_command_r <= MC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEEL_BASE:  wheel_base_r  <= cfg_data[WB_W-1:0];
        CFG_MAX_SPEED:   max_speed_r   <= cfg_data[MS_W-1:0];
        CFG_MIN_COMMAND: min_command_r <= cfg_data[MC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [MS_W-1:0]  ms_eff;
  logic [LIM_W-1:0] lim;
  logic [QW-1:0]    m_fix;
  assign ms_eff = (max_speed_r == '0) ? MS_W'(1) : max_speed_r;
  assign lim    = {ms_eff, {LIM_SHIFT{1'b0}}};
  assign m_fix  = {min_command_r, {FRAC_BITS{1'b0}}};

  // stage 1: scaled linear term and turn product
  logic signed [SUM_W-1:0] base_nxt, turn_nxt, base_r, turn_r;
  logic vld1_r;
  assign base_nxt = {{2{in_linear_speed[SPEED_WIDTH-1]}}, in_linear_speed, {LIM_SHIFT{1'b0}}};
  assign turn_nxt = in_turn_rate * $signed({1'b0, wheel_base_r});

  // stage 2: wheel speeds, lane 0 left, lane 1 right
  logic signed [SUM_W-1:0] spd_nxt [2];
  logic signed [SUM_W-1:0] spd_r   [2];
  logic vld2_r;
  assign spd_nxt[0] = base_r - turn_r;
  assign spd_nxt[1] = base_r + turn_r;

  // stage 3: magnitude clamped to full scale
  logic [LIM_W-1:0] magc_nxt [2];
  logic [LIM_W-1:0] magc_r   [2];
  logic [1:0]       sgn3_nxt, sgn3_r;
  logic             vld3_r;

  always_comb begin
    logic [SUM_W-1:0] mag;
    logic [CW-1:0]    mag_ext;
    for (int l = 0; l < 2; l++) begin
      sgn3_nxt[l] = spd_r[l][SUM_W-1];
      mag         = spd_r[l][SUM_W-1] ? unsigned'(-spd_r[l]) : unsigned'(spd_r[l]);
      mag_ext     = CW'(mag);
      magc_nxt[l] = (mag_ext > CW'(lim)) ? lim : LIM_W'(mag_ext);
    end
  end

  // stage 4: times 127
  logic [P1_W-1:0] p1_nxt [2];
  logic [P1_W-1:0] p1_r   [2];
  logic [1:0]      sgn4_r;
  logic            vld4_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p1_nxt[l] = {magc_r[l], {CMD_MAG_W{1'b0}}} - P1_W'(magc_r[l]);
    end
  end

  // first divider: command with fraction bits
  logic [LIM_W-1:0] d1_rem [2];
  logic [QW-1:0]    d1_low [2];
  logic [LIM_W-1:0] d1_div [2];
  logic             d1_vld;
  logic [QW-1:0]    d1_quo [2];
  logic [1:0]       d1_side;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      d1_rem[l] = p1_r[l][P1_W-1:CMD_MAG_W];
      d1_low[l] = {p1_r[l][CMD_MAG_W-1:0], {FRAC_BITS{1'b0}}};
      d1_div[l] = lim;
    end
  end

  dmm_div_pipe #(
    .LANES (2),
    .DW    (LIM_W),
    .QW    (QW),
    .SW    (2)
  ) u_div_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld4_r),
    .in_rem    (d1_rem),
    .in_low    (d1_low),
    .in_div    (d1_div),
    .in_side   (sgn4_r),
    .out_valid (d1_vld),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  // stage 5: smallest command below the minimum
  logic [QW-1:0] c5_r [2];
  logic [QW-1:0] d5_nxt, d5_r;
  logic          scl5_nxt, scl5_r;
  logic [1:0]    sgn5_r;
  logic          vld5_r;

  always_comb begin
    logic cand_l, cand_r;
    cand_l   = (d1_quo[0] != '0) && (d1_quo[0] < m_fix);
    cand_r   = (d1_quo[1] != '0) && (d1_quo[1] < m_fix);
    scl5_nxt = cand_l || cand_r;
    if (cand_l && cand_r) begin
      d5_nxt = (d1_quo[1] < d1_quo[0]) ? d1_quo[1] : d1_quo[0];
    end else if (cand_l) begin
      d5_nxt = d1_quo[0];
    end else if (cand_r) begin
      d5_nxt = d1_quo[1];
    end else begin
      d5_nxt = '0;
    end
  end

  // stage 6: rescale product
  logic [P2_W-1:0] p2_nxt [2];
  logic [P2_W-1:0] p2_r   [2];
  logic [QW-1:0]   d6_r;
  logic            scl6_r;
  logic [1:0]      sgn6_r;
  logic            vld6_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p2_nxt[l] = scl5_r ? (P2_W'(c5_r[l]) * P2_W'(m_fix)) : P2_W'(c5_r[l]);
    end
  end

  // second divider: rescaled command, overflow saturates
  logic [QW-1:0] d2_rem [2];
  logic [QW-1:0] d2_low [2];
  logic [QW-1:0] d2_div [2];
  logic [3:0]    d2_side_in;
  logic          d2_vld;
  logic [QW-1:0] d2_quo [2];
  logic [3:0]    d2_side;

  always_comb begin
    d2_side_in[1:0] = sgn6_r;
    for (int l = 0; l < 2; l++) begin
      d2_rem[l] = p2_r[l][P2_W-1:QW];
      d2_low[l] = p2_r[l][QW-1:0];
      d2_div[l] = scl6_r ? d6_r : QW'(1);
      d2_side_in[2+l] = scl6_r && (p2_r[l][P2_W-1:QW] >= d6_r);
    end
  end

  dmm_div_pipe #(
    .LANES (2),
    .DW    (QW),
    .QW    (QW),
    .SW    (4)
  ) u_div_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld6_r),
    .in_rem    (d2_rem),
    .in_low    (d2_low),
    .in_div    (d2_div),
    .in_side   (d2_side_in),
    .out_valid (d2_vld),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  // output stage: clamp, drop fraction, apply sign
  logic [CMD_W-1:0]  cmd_nxt [2];
  logic [CMD_W-1:0]  cmd_r   [2];

  always_comb begin
    logic [QW-1:0]    qs;
    logic [CMD_W-1:0] mag8;
    for (int l = 0; l < 2; l++) begin
      qs      = (d2_side[2+l] || (d2_quo[l] > FULL)) ? FULL : d2_quo[l];
      mag8    = {1'b0, qs[QW-1:FRAC_BITS]};
      cmd_nxt[l] = d2_side[l] ? (~mag8 + CMD_W'(1)) : mag8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      vld5_r      <= 1'b0;
      vld6_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld1_r      <= in_valid;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld4_r      <= vld3_r;
      vld5_r      <= d1_vld;
      vld6_r      <= vld5_r;
      out_valid_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r   <= base_nxt;
      turn_r   <= turn_nxt;
      spd_r    <= spd_nxt;
      magc_r   <= magc_nxt;
      sgn3_r   <= sgn3_nxt;
      p1_r     <= p1_nxt;
      sgn4_r   <= sgn3_r;
      c5_r     <= d1_quo;
      d5_r     <= d5_nxt;
      scl5_r   <= scl5_nxt;
      sgn5_r   <= d1_side;
      p2_r     <= p2_nxt;
      d6_r     <= d5_r;
      scl6_r   <= scl5_r;
      sgn6_r   <= sgn5_r;
      cmd_r    <= cmd_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_command  = cmd_r[0];
  assign out_right_command = cmd_r[1];

endmodule

FILE: src/dmm_checker.sv
// Port-level assertions for the motor mixer, bound to the top level.
module dmm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [dmm_pkg::CMD_W-1:0] out_left_command,
  input logic signed [dmm_pkg::CMD_W-1:0] out_right_command
);

  import dmm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NEG_LIMIT = {1'b1, {(CMD_W-1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_command)
      && $stable(out_right_command))
    else $error("stalled result changed");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_command != CMD_NEG_LIMIT)
      && (out_right_command != CMD_NEG_LIMIT))
    else $error("command outside -127..127");

  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind diff_drive_motor_mixer dmm_checker u_dmm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_left_command  (out_left_command),
  .out_right_command (out_right_command)
);
